### rtl/sidac_pkg.sv
// Shared types, constants and power-of-ten tables for the decimal ASCII converter.
// Used by sidac_ctrl, sidac_dp and signed_int_to_decimal_ascii_core; no dependencies.
package sidac_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGIT_W = 4;
    // decimal position of the leading digit, 0..9
    localparam int unsigned EXP_W   = 4;
    // wide enough for 9 * 10^9
    localparam int unsigned THR_W   = 34;
    localparam int unsigned MAX_EXP = 9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIZE,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic size;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic neg;
        logic exp_zero;
    } t_dp_status;

    // 10^exp, constant table
    function automatic logic [THR_W-1:0] pow10(input logic [EXP_W-1:0] exp);
        logic [THR_W-1:0] p;
        begin
            case (exp)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                default: p = 34'd0;
            endcase
            return p;
        end
    endfunction

    // d * 10^exp; d is always an elaboration-time constant at the call site
    function automatic logic [THR_W-1:0] digit_thresh(input logic [EXP_W-1:0] exp,
                                                      input int unsigned d);
        logic [THR_W-1:0] p;
        begin
            p = pow10(exp);
            return THR_W'(p * THR_W'(d));
        end
    endfunction

endpackage

### rtl/sidac_dp.sv
// Datapath of the decimal ASCII converter: magnitude, digit position and output character.
// Depends on sidac_pkg; driven by sidac_ctrl through t_dp_cmd.
module sidac_dp (
    input  logic                               i_clk,
    input  logic signed [sidac_pkg::VALUE_W-1:0] i_value,
    input  sidac_pkg::t_dp_cmd                 i_cmd,
    output sidac_pkg::t_dp_status              o_status,
    output logic [sidac_pkg::CHAR_W-1:0]       o_character,
    output logic                               o_last
);

    logic [sidac_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic [sidac_pkg::EXP_W-1:0]   r_exp, n_exp;
    logic [sidac_pkg::CHAR_W-1:0]  r_char, n_char;
    logic                          r_last, n_last;

    logic [sidac_pkg::VALUE_W-1:0] raw;
    logic [sidac_pkg::EXP_W-1:0]   size_cnt;
    logic [sidac_pkg::THR_W-1:0]   thr [10];
    logic [sidac_pkg::DIGIT_W-1:0] digit;
    logic [sidac_pkg::THR_W-1:0]   mag_ext;
    logic [sidac_pkg::THR_W-1:0]   mag_rem;

    assign raw     = i_value;
    assign mag_ext = {2'b00, r_mag};

    // leading digit position: how many of 10^1..10^9 the magnitude reaches
    always_comb begin
        size_cnt = '0;
        for (int k = 1; k <= sidac_pkg::MAX_EXP; k++) begin
            if (mag_ext >= sidac_pkg::pow10(sidac_pkg::EXP_W'(k))) begin
                size_cnt = size_cnt + 1'b1;
            end
        end
    end

    // current digit: count of multiples d * 10^exp that fit
    always_comb begin
        thr[0] = '0;
        digit  = '0;
        for (int d = 1; d <= 9; d++) begin
            thr[d] = sidac_pkg::digit_thresh(r_exp, d);
            if (mag_ext >= thr[d]) begin
                digit = digit + 1'b1;
            end
        end
        mag_rem = mag_ext - thr[digit];
    end

    // register updates per command
    always_comb begin
        n_mag  = r_mag;
        n_neg  = r_neg;
        n_exp  = r_exp;
        n_char = r_char;
        n_last = r_last;
        if (i_cmd.load) begin
            n_neg = raw[sidac_pkg::VALUE_W-1];
            n_mag = raw[sidac_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
        end
        if (i_cmd.size) begin
            n_exp = size_cnt;
        end
        if (i_cmd.emit_sign) begin
            n_char = sidac_pkg::CH_MINUS;
            n_last = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_char = sidac_pkg::CH_ZERO + {4'b0000, digit};
            n_last = (r_exp == '0);
            n_mag  = mag_rem[sidac_pkg::VALUE_W-1:0];
            n_exp  = r_exp - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_exp  <= n_exp;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_status.neg      = r_neg;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_character       = r_char;
    assign o_last            = r_last;

endmodule

### rtl/sidac_ctrl.sv
// Controller of the decimal ASCII converter: sequences load, sizing, sign and digit beats.
// Depends on sidac_pkg; commands sidac_dp and owns both handshakes.
module sidac_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  sidac_pkg::t_dp_status i_status,
    output sidac_pkg::t_dp_cmd    o_cmd
);

    sidac_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              slot_free;

    // output register can take a new beat
    assign slot_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sidac_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = sidac_pkg::ST_SIZE;
                end
            end
            sidac_pkg::ST_SIZE: begin
                n_state = i_status.neg ? sidac_pkg::ST_SIGN : sidac_pkg::ST_DIGIT;
            end
            sidac_pkg::ST_SIGN: begin
                if (slot_free) begin
                    n_state = sidac_pkg::ST_DIGIT;
                end
            end
            sidac_pkg::ST_DIGIT: begin
                if (slot_free && i_status.exp_zero) begin
                    n_state = sidac_pkg::ST_IDLE;
                end
            end
            default: n_state = sidac_pkg::ST_IDLE;
        endcase
    end

    // commands and output valid
    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            sidac_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            sidac_pkg::ST_SIZE: begin
                o_cmd.size = 1'b1;
            end
            sidac_pkg::ST_SIGN: begin
                o_cmd.emit_sign = slot_free;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                end
            end
            sidac_pkg::ST_DIGIT: begin
                o_cmd.emit_digit = slot_free;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sidac_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### rtl/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// Input channel: i_valid / o_ready with i_value. Output channel: o_valid / i_ready
// with o_character and o_last; o_last marks the final character of a number.
// Negative values start with '-', digits follow most significant first, no
// leading zeros; zero gives "0"; -2147483648 gives "-2147483648".
// Timing: the accept cycle takes the magnitude, the ST_SIZE state then finds
// the leading digit position, then one character per cycle while the receiver
// does not stall (an optional '-' and 1..10 digits), each digit picked by one
// bank of nine compares against d * 10^k.
// With a sign the first character is the '-', and the first digit follows it.
// The output register lets the next item be accepted while the final
// character still waits to be taken.
// A stalled receiver (i_ready low) holds the current character and pauses
// the conversion; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) returns to idle and drops any character in
// flight; no state carries between items.
module signed_int_to_decimal_ascii_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [sidac_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sidac_pkg::CHAR_W-1:0]        o_character,
    output logic                                o_last
);

    sidac_pkg::t_dp_cmd    cmd;
    sidac_pkg::t_dp_status status;

    sidac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sidac_dp u_dp (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
